// ===== rtl/core/icmph_pkg.sv =====
// icmpv4 header parser package: constants, status codes and shared types
`timescale 1ns / 1ps

package icmph_pkg;

  localparam logic [15:0] MaxMsgLen = 16'hFFFF;
  localparam logic [15:0] HdrLen    = 16'd8;
  localparam logic [15:0] IpHdrLen  = 16'd20;
  localparam logic [15:0] PortsLen  = 16'd4;
  localparam logic [15:0] SmallL4Len = 16'd8;

  // message offsets of captured bytes
  localparam logic [15:0] PosType     = 16'd0;
  localparam logic [15:0] PosCode     = 16'd1;
  localparam logic [15:0] PosIdFirst  = 16'd4;
  localparam logic [15:0] PosIdLast   = 16'd7;
  localparam logic [15:0] PosVersion  = 16'd8;
  localparam logic [15:0] PosProto    = 16'd17;
  localparam logic [15:0] PosAddrFirst = 16'd20;
  localparam logic [15:0] PosAddrLast  = 16'd27;
  localparam logic [15:0] PosPortFirst = 16'd28;
  localparam logic [15:0] PosPortLast  = 16'd31;

  localparam logic [7:0] TypeEchoReply   = 8'd0;
  localparam logic [7:0] TypeDestUnreach = 8'd3;
  localparam logic [7:0] TypeSrcQuench   = 8'd4;
  localparam logic [7:0] TypeRedirect    = 8'd5;
  localparam logic [7:0] TypeEchoReq     = 8'd8;
  localparam logic [7:0] TypeTimeExceed  = 8'd11;
  localparam logic [7:0] TypeParamProb   = 8'd12;
  localparam logic [7:0] TypeTsReq       = 8'd13;
  localparam logic [7:0] TypeTsReply     = 8'd14;
  localparam logic [7:0] TypeInfoReq     = 8'd15;
  localparam logic [7:0] TypeInfoReply   = 8'd16;
  localparam logic [7:0] TypeMaskReq     = 8'd17;
  localparam logic [7:0] TypeMaskReply   = 8'd18;

  localparam logic [7:0] MaxCodeUnreach = 8'd15;
  localparam logic [7:0] MaxCodeRedir   = 8'd3;
  localparam logic [7:0] MaxCodeTime    = 8'd1;
  localparam logic [7:0] MaxCodeParam   = 8'd0;

  localparam logic [3:0] IpVersion4 = 4'd4;
  localparam logic [7:0] ProtoIcmp  = 8'd1;
  localparam logic [7:0] ProtoTcp   = 8'd6;
  localparam logic [7:0] ProtoUdp   = 8'd17;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_TOO_SMALL   = 3'd1,
    STATUS_UNK_TYPE    = 3'd2,
    STATUS_UNK_CODE    = 3'd3,
    STATUS_EMB_TRUNC   = 3'd4,
    STATUS_EMB_BAD_VER = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [31:0] id_seq;
    logic [3:0]  emb_version;
    logic [7:0]  emb_proto_raw;
    logic [63:0] emb_addrs;
    logic [31:0] emb_ports;
  } capt_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
    status_e     status;
    logic        emb_valid;
    logic [31:0] emb_src_addr;
    logic [31:0] emb_dst_addr;
    logic [7:0]  emb_proto;
    logic [15:0] emb_src_port;
    logic [15:0] emb_dst_port;
    logic [15:0] body_len;
  } result_t;

endpackage

// ===== rtl/core/icmph_if.sv =====
// icmpv4 header parser channel interfaces: byte input and result output
`timescale 1ns / 1ps

interface icmph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface icmph_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  msg_type;
  logic [7:0]  msg_code;
  logic [15:0] echo_id;
  logic [15:0] echo_seq;
  logic [2:0]  status;
  logic        emb_valid;
  logic [31:0] emb_src_addr;
  logic [31:0] emb_dst_addr;
  logic [7:0]  emb_proto;
  logic [15:0] emb_src_port;
  logic [15:0] emb_dst_port;
  logic [15:0] body_len;

  modport source (
    output valid, output msg_type, output msg_code, output echo_id, output echo_seq,
    output status, output emb_valid, output emb_src_addr, output emb_dst_addr,
    output emb_proto, output emb_src_port, output emb_dst_port, output body_len,
    input ready
  );
  modport sink (
    input valid, input msg_type, input msg_code, input echo_id, input echo_seq,
    input status, input emb_valid, input emb_src_addr, input emb_dst_addr,
    input emb_proto, input emb_src_port, input emb_dst_port, input body_len,
    output ready
  );
endinterface

// ===== rtl/core/icmph_decode.sv =====
// icmpv4 header parser result decode from the captured header fields
`timescale 1ns / 1ps

module icmph_decode (
  input  icmph_pkg::capt_t   capt_i,
  output icmph_pkg::result_t result_o
);

  logic [15:0] len;
  logic [15:0] elen;
  logic [7:0]  max_code;
  logic        run_emb;

  assign len  = capt_i.byte_count;
  assign elen = len - icmph_pkg::HdrLen;

  always_comb begin
    case (capt_i.msg_type)
      icmph_pkg::TypeDestUnreach: max_code = icmph_pkg::MaxCodeUnreach;
      icmph_pkg::TypeRedirect:    max_code = icmph_pkg::MaxCodeRedir;
      icmph_pkg::TypeTimeExceed:  max_code = icmph_pkg::MaxCodeTime;
      default:                    max_code = icmph_pkg::MaxCodeParam;
    endcase
  end

  always_comb begin
    result_o = '0;
    result_o.status = icmph_pkg::STATUS_OK;
    run_emb = 1'b0;
    if (len < icmph_pkg::HdrLen) begin
      result_o.status = icmph_pkg::STATUS_TOO_SMALL;
    end else begin
      result_o.msg_type    = capt_i.msg_type;
      result_o.msg_code    = capt_i.msg_code;
      result_o.body_len    = elen;
      case (capt_i.msg_type) inside
        icmph_pkg::TypeEchoReply, icmph_pkg::TypeEchoReq, icmph_pkg::TypeTsReq,
        icmph_pkg::TypeTsReply, icmph_pkg::TypeInfoReq, icmph_pkg::TypeInfoReply,
        icmph_pkg::TypeMaskReq, icmph_pkg::TypeMaskReply: begin
          result_o.echo_id  = capt_i.id_seq[31:16];
          result_o.echo_seq = capt_i.id_seq[15:0];
          if (capt_i.msg_code != 8'd0) result_o.status = icmph_pkg::STATUS_UNK_CODE;
        end
        icmph_pkg::TypeDestUnreach, icmph_pkg::TypeRedirect,
        icmph_pkg::TypeTimeExceed, icmph_pkg::TypeParamProb: begin
          if (capt_i.msg_code > max_code) result_o.status = icmph_pkg::STATUS_UNK_CODE;
          else run_emb = (len > icmph_pkg::HdrLen);
        end
        icmph_pkg::TypeSrcQuench: begin
          if (capt_i.msg_code != 8'd0) result_o.status = icmph_pkg::STATUS_UNK_CODE;
          else run_emb = 1'b1;
        end
        default: begin
          result_o.status = icmph_pkg::STATUS_UNK_TYPE;
        end
      endcase

      // embedded ipv4 header
      if (run_emb) begin
        if (elen < icmph_pkg::IpHdrLen) begin
          result_o.status = icmph_pkg::STATUS_EMB_TRUNC;
        end else if (capt_i.emb_version != icmph_pkg::IpVersion4) begin
          result_o.status = icmph_pkg::STATUS_EMB_BAD_VER;
        end else begin
          result_o.emb_valid    = 1'b1;
          result_o.emb_src_addr = capt_i.emb_addrs[63:32];
          result_o.emb_dst_addr = capt_i.emb_addrs[31:0];
          if ((capt_i.emb_proto_raw == icmph_pkg::ProtoTcp &&
               elen >= icmph_pkg::IpHdrLen + icmph_pkg::PortsLen) ||
              (capt_i.emb_proto_raw == icmph_pkg::ProtoUdp &&
               elen >= icmph_pkg::IpHdrLen + icmph_pkg::SmallL4Len)) begin
            result_o.emb_proto    = capt_i.emb_proto_raw;
            result_o.emb_src_port = capt_i.emb_ports[31:16];
            result_o.emb_dst_port = capt_i.emb_ports[15:0];
          end else if (capt_i.emb_proto_raw == icmph_pkg::ProtoIcmp &&
                       elen >= icmph_pkg::IpHdrLen + icmph_pkg::SmallL4Len) begin
            result_o.emb_proto = icmph_pkg::ProtoIcmp;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/icmpv4_header_parser_core.sv =====
// icmpv4 header parser top level: byte capture, result decode and output buffer
`timescale 1ns / 1ps

// Takes an ICMPv4 message one byte per item, with last on the final byte, and
// gives exactly one result item for each message; when its last byte is taken
// the result is registered in the result register, or in the skid register
// while the result register holds one. Header fields are captured into registers
// at fixed offsets as bytes arrive, on the last byte a short decode feeds the
// buffer, and a new byte can be taken in every cycle unless the input stalls: a
// two-entry output buffer (result register plus skid register) lets input go on
// while a result waits; input stalls only when both entries are full. The
// byte count saturates at 65535; ports are at offset 20 of the embedded header.

module icmpv4_header_parser_core (
  input logic           clk_i,
  input logic           rst_ni,
  icmph_in_if.sink      in_i,
  icmph_out_if.source   out_o
);

  icmph_pkg::capt_t   capt_q, capt_d, capt_upd;
  icmph_pkg::result_t res;
  icmph_pkg::result_t out_q, skid_q;
  logic               out_valid_q, skid_valid_q;
  logic               accept, push, pop;
  logic [15:0]        pos;
  logic [7:0]         b;

  assign in_i.ready = ~skid_valid_q;
  assign accept     = in_i.valid & in_i.ready;
  assign push       = accept & in_i.last;
  assign pop        = out_valid_q & out_o.ready;
  assign pos        = capt_q.byte_count;
  assign b          = in_i.data_byte;

  // capture of the current byte at its offset
  always_comb begin
    capt_upd = capt_q;
    if (pos == icmph_pkg::PosType) begin
      capt_upd.msg_type = b;
    end else if (pos == icmph_pkg::PosCode) begin
      capt_upd.msg_code = b;
    end else if (pos >= icmph_pkg::PosIdFirst && pos <= icmph_pkg::PosIdLast) begin
      case (pos[1:0])
        2'd0:    capt_upd.id_seq[31:24] = b;
        2'd1:    capt_upd.id_seq[23:16] = b;
        2'd2:    capt_upd.id_seq[15:8]  = b;
        default: capt_upd.id_seq[7:0]   = b;
      endcase
    end else if (pos == icmph_pkg::PosVersion) begin
      capt_upd.emb_version = b[7:4];
    end else if (pos == icmph_pkg::PosProto) begin
      capt_upd.emb_proto_raw = b;
    end else if (pos >= icmph_pkg::PosAddrFirst && pos <= icmph_pkg::PosAddrLast) begin
      case (pos[2:0])
        3'd4:    capt_upd.emb_addrs[63:56] = b;
        3'd5:    capt_upd.emb_addrs[55:48] = b;
        3'd6:    capt_upd.emb_addrs[47:40] = b;
        3'd7:    capt_upd.emb_addrs[39:32] = b;
        3'd0:    capt_upd.emb_addrs[31:24] = b;
        3'd1:    capt_upd.emb_addrs[23:16] = b;
        3'd2:    capt_upd.emb_addrs[15:8]  = b;
        default: capt_upd.emb_addrs[7:0]   = b;
      endcase
    end else if (pos >= icmph_pkg::PosPortFirst && pos <= icmph_pkg::PosPortLast) begin
      case (pos[1:0])
        2'd0:    capt_upd.emb_ports[31:24] = b;
        2'd1:    capt_upd.emb_ports[23:16] = b;
        2'd2:    capt_upd.emb_ports[15:8]  = b;
        default: capt_upd.emb_ports[7:0]   = b;
      endcase
    end
    if (pos != icmph_pkg::MaxMsgLen) capt_upd.byte_count = pos + 16'd1;
  end

  always_comb begin
    capt_d = capt_q;
    if (accept) capt_d = in_i.last ? '0 : capt_upd;
  end

  icmph_decode u_decode (
    .capt_i   (capt_upd),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capt_q       <= '0;
      out_q        <= '0;
      skid_q       <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      capt_q <= capt_d;
      if (pop || !out_valid_q) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push;
          if (push) out_q <= res;
        end
      end else if (push) begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.msg_type     = out_q.msg_type;
  assign out_o.msg_code     = out_q.msg_code;
  assign out_o.echo_id      = out_q.echo_id;
  assign out_o.echo_seq     = out_q.echo_seq;
  assign out_o.status       = out_q.status;
  assign out_o.emb_valid    = out_q.emb_valid;
  assign out_o.emb_src_addr = out_q.emb_src_addr;
  assign out_o.emb_dst_addr = out_q.emb_dst_addr;
  assign out_o.emb_proto    = out_q.emb_proto;
  assign out_o.emb_src_port = out_q.emb_src_port;
  assign out_o.emb_dst_port = out_q.emb_dst_port;
  assign out_o.body_len     = out_q.body_len;

endmodule
